@@ rtl/core/rims_pkg.sv @@
// Shared types and constants for the run insertion / merge sorter.
package rims_pkg;
    localparam int ValueWidth = 64;
    typedef logic [ValueWidth-1:0] value_t;
    // Beat carried from the front (collector) to the back (sorter).
    typedef struct packed {
        value_t value;
        logic   last;
        logic   drop;
    } item_t;
    // Signed greater-than on two's complement patterns.
    function automatic logic sgt(input value_t a, input value_t b);
        sgt = $signed(a) > $signed(b);
    endfunction
endpackage

@@ rtl/core/rims_ram.sv @@
// Generic single-write, single-read RAM with registered read.
module rims_ram #(
    parameter int Width = 64,
    parameter int Depth = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/core/rims_front.sv @@
// Input collector: classifies beats into stored, dropped and last, through a small queue.
module rims_front #(
    parameter int MaxItems = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  rims_pkg::value_t        s_value,
    input  logic                    s_last,
    output logic                    q_valid,
    input  logic                    q_ready,
    output rims_pkg::item_t         q_item
);
    import rims_pkg::*;
    localparam int CW = $clog2(MaxItems + 1);
    logic [CW-1:0] cnt_reg, cnt_next;
    item_t buf_reg [2];
    logic rd_reg, wr_reg;
    logic [1:0] fill_reg;
    logic push, pop, full;

    assign full     = (cnt_reg == CW'(MaxItems));
    assign s_tready = (fill_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (fill_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = buf_reg[rd_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push) cnt_next = s_last ? '0 : (full ? cnt_reg : cnt_reg + 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            rd_reg   <= 1'b0;
            wr_reg   <= 1'b0;
            fill_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wr_reg <= ~wr_reg;
            if (pop) rd_reg <= ~rd_reg;
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) buf_reg[wr_reg] <= '{value: s_value, last: s_last, drop: full};
    end
endmodule

@@ rtl/core/rims_back.sv @@
// Sort engine: stores items, insertion-sorts runs, merges runs and streams the result.
module rims_back #(
    parameter int MaxItems  = 64,
    parameter int RunLength = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  rims_pkg::item_t   q_item,
    output logic              m_tvalid,
    input  logic              m_tready,
    output rims_pkg::value_t  m_value,
    output logic              m_last,
    output logic              m_overflow
);
    import rims_pkg::*;
    localparam int AW = (MaxItems > 1) ? $clog2(MaxItems) : 1;
    localparam int CW = $clog2(MaxItems + 1);
    localparam int WW = $clog2(2 * MaxItems + 2 * RunLength + 1);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_IOUT  = 4'd1;  // outer insertion step: fetch t
    localparam logic [3:0] S_IRD   = 4'd2;  // read store[j-1]
    localparam logic [3:0] S_ICMP  = 4'd3;
    localparam logic [3:0] S_MCPY  = 4'd4;  // copy store -> scratch
    localparam logic [3:0] S_MRD   = 4'd5;  // read scratch[a], or scratch[b] once run a is exhausted
    localparam logic [3:0] S_MRDB  = 4'd6;
    localparam logic [3:0] S_MCMP  = 4'd7;
    localparam logic [3:0] S_ORD   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_ITAIL = 4'd10;
    localparam logic [3:0] S_MNEXT = 4'd11;
    localparam logic [3:0] S_CWAIT = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [CW-1:0] n_reg, n_next;
    logic ovf_reg, ovf_next;
    logic [WW-1:0] lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [WW-1:0] i_reg, i_next, j_reg, j_next, w_reg, w_next;
    logic [WW-1:0] a_reg, a_next, b_reg, b_next, k_reg, k_next;
    value_t t_reg, t_next, va_reg, va_next;
    logic out_valid_reg, out_valid_next;
    value_t out_val_reg, out_val_next;
    logic out_last_reg, out_last_next;

    logic st_we, sc_we;
    logic [AW-1:0] st_wa, st_ra, sc_wa, sc_ra;
    value_t st_wd, st_rd, sc_wd, sc_rd;

    rims_ram #(.Width(ValueWidth), .Depth(MaxItems)) u_store (
        .aclk(aclk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd)
    );
    rims_ram #(.Width(ValueWidth), .Depth(MaxItems)) u_scratch (
        .aclk(aclk), .we(sc_we), .waddr(sc_wa), .wdata(sc_wd), .raddr(sc_ra), .rdata(sc_rd)
    );

    assign q_ready    = (state_reg == S_LOAD);
    assign m_tvalid   = out_valid_reg;
    assign m_value    = out_val_reg;
    assign m_last     = out_last_reg;
    assign m_overflow = ovf_reg;

    logic [WW-1:0] nw, run_hi, m_hi;
    always_comb begin
        nw     = WW'(n_reg);
        run_hi = (lo_reg + WW'(RunLength) > nw) ? nw : lo_reg + WW'(RunLength);
        m_hi   = (lo_reg + (w_reg << 1) > nw) ? nw : lo_reg + (w_reg << 1);
    end

    always_comb begin
        state_next = state_reg; n_next = n_reg; ovf_next = ovf_reg;
        lo_next = lo_reg; hi_next = hi_reg; mid_next = mid_reg;
        i_next = i_reg; j_next = j_reg; w_next = w_reg;
        a_next = a_reg; b_next = b_reg; k_next = k_reg;
        t_next = t_reg; va_next = va_reg;
        out_valid_next = out_valid_reg; out_val_next = out_val_reg;
        out_last_next = out_last_reg;
        st_we = 1'b0; st_wa = '0; st_wd = '0; st_ra = '0;
        sc_we = 1'b0; sc_wa = '0; sc_wd = '0; sc_ra = '0;
        if (out_valid_reg && m_tready) out_valid_next = 1'b0;
        unique case (state_reg)
            S_LOAD: begin
                if (q_valid) begin
                    if (q_item.drop) ovf_next = 1'b1;
                    else begin
                        st_we = 1'b1; st_wa = AW'(n_reg); st_wd = q_item.value;
                        n_next = n_reg + 1'b1;
                    end
                    if (q_item.last) begin
                        lo_next = '0;
                        i_next = WW'(1);
                        state_next = S_IOUT;
                    end
                end
            end
            S_IOUT: begin
                // i walks the current run; when done move to next run or to merging
                if (lo_reg >= nw) begin
                    w_next = WW'(RunLength); lo_next = '0; state_next = S_MNEXT;
                end else if (i_reg >= run_hi) begin
                    lo_next = lo_reg + WW'(RunLength);
                    i_next = lo_reg + WW'(RunLength) + 1'b1;
                end else begin
                    st_ra = AW'(i_reg); j_next = i_reg; state_next = S_ITAIL;
                end
            end
            S_ITAIL: begin
                t_next = st_rd; state_next = S_IRD;
            end
            S_IRD: begin
                if (j_reg > lo_reg) begin
                    st_ra = AW'(j_reg - 1'b1); state_next = S_ICMP;
                end else begin
                    st_we = 1'b1; st_wa = AW'(j_reg); st_wd = t_reg;
                    i_next = i_reg + 1'b1; state_next = S_IOUT;
                end
            end
            S_ICMP: begin
                if (sgt(st_rd, t_reg)) begin
                    st_we = 1'b1; st_wa = AW'(j_reg); st_wd = st_rd;
                    j_next = j_reg - 1'b1; state_next = S_IRD;
                end else begin
                    st_we = 1'b1; st_wa = AW'(j_reg); st_wd = t_reg;
                    i_next = i_reg + 1'b1; state_next = S_IOUT;
                end
            end
            S_MNEXT: begin
                // pick the next pair of runs to merge, or go to output once one run spans the set
                if (w_reg >= nw) begin
                    k_next = '0; state_next = S_ORD;
                end else if (lo_reg >= nw || lo_reg + w_reg >= nw) begin
                    w_next = w_reg << 1; lo_next = '0;
                end else begin
                    mid_next = lo_reg + w_reg; hi_next = m_hi;
                    k_next = lo_reg; state_next = S_MCPY;
                    st_ra = AW'(lo_reg);
                end
            end
            S_MCPY: begin
                // store read data is registered: k tracks the write side
                sc_we = 1'b1; sc_wa = AW'(k_reg); sc_wd = st_rd;
                if (k_reg + 1'b1 >= hi_reg) begin
                    a_next = lo_reg; b_next = mid_reg; k_next = lo_reg; state_next = S_MRD;
                end else begin
                    st_ra = AW'(k_reg + 1'b1); k_next = k_reg + 1'b1;
                end
            end
            S_MRD: begin
                if (k_reg >= hi_reg) begin
                    lo_next = lo_reg + (w_reg << 1); state_next = S_MNEXT;
                end else begin
                    sc_ra = AW'((a_reg < mid_reg) ? a_reg : b_reg); state_next = S_MRDB;
                end
            end
            S_MRDB: begin
                va_next = sc_rd;
                sc_ra = AW'(b_reg);
                state_next = (a_reg < mid_reg && b_reg < hi_reg) ? S_MCMP : S_CWAIT;
            end
            S_CWAIT: begin
                // one side exhausted: copy the value already read
                st_we = 1'b1; st_wa = AW'(k_reg); st_wd = va_reg;
                k_next = k_reg + 1'b1;
                if (a_reg < mid_reg) a_next = a_reg + 1'b1; else b_next = b_reg + 1'b1;
                state_next = S_MRD;
            end
            S_MCMP: begin
                st_we = 1'b1; st_wa = AW'(k_reg); k_next = k_reg + 1'b1;
                if (!sgt(va_reg, sc_rd)) begin
                    st_wd = va_reg; a_next = a_reg + 1'b1;
                end else begin
                    st_wd = sc_rd; b_next = b_reg + 1'b1;
                end
                state_next = S_MRD;
            end
            S_ORD: begin
                st_ra = AW'(k_reg); state_next = S_OUT;
            end
            S_OUT: begin
                // hold the read address so the data survives an output stall
                st_ra = AW'(k_reg);
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1; out_val_next = st_rd;
                    out_last_next = (k_reg + 1'b1 == nw);
                    k_next = k_reg + 1'b1;
                    if (k_reg + 1'b1 == nw) begin
                        state_next = S_DONE;
                    end else state_next = S_ORD;
                end
            end
            S_DONE: begin
                // wait for the final beat to drain, then clear the set
                if (!out_valid_reg || m_tready) begin
                    n_next = '0; ovf_next = 1'b0; state_next = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD; n_reg <= '0; ovf_reg <= 1'b0; out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next; n_reg <= n_next; ovf_reg <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
        lo_reg <= lo_next; hi_reg <= hi_next; mid_reg <= mid_next;
        i_reg <= i_next; j_reg <= j_next; w_reg <= w_next;
        a_reg <= a_next; b_reg <= b_next; k_reg <= k_next;
        t_reg <= t_next; va_reg <= va_next;
        out_val_reg <= out_val_next; out_last_reg <= out_last_next;
    end
endmodule

@@ rtl/core/run_insertion_merge_sorter.sv @@
// Top level of the run insertion / merge sorter.
//  channel | dir | tdata          | tuser    | tlast
//  s_      | in  | value_in[63:0] | -        | last_in
//  m_      | out | value_out      | overflow | last_out
// Loading takes one beat per cycle while the sort engine is loading. Insertion, the
// copy to scratch and output use the store RAM's single read port; merging reads
// scratch. Each merged element is copied to scratch, then compared and written back.
// Reset is synchronous and clears control state only. Input passes through a 2-beat
// queue and stalls while the engine sorts or streams a set.
module run_insertion_merge_sorter #(
    parameter int MAX_ITEMS  = 64,
    parameter int RUN_LENGTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // value_in
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // value_out
    output logic        m_tuser,   // overflow
    output logic        m_tlast
);
    import rims_pkg::*;
    logic q_valid, q_ready;
    item_t q_item;

    rims_front #(.MaxItems(MAX_ITEMS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_value(s_tdata), .s_last(s_tlast),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );
    rims_back #(.MaxItems(MAX_ITEMS), .RunLength(RUN_LENGTH)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_item(q_item), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_value(m_tdata), .m_last(m_tlast), .m_overflow(m_tuser)
    );
endmodule

@@ test/run_insertion_merge_sorter_chk.sv @@
// Checker for the run insertion / merge sorter: predicts sorted sets and compares output beats.
module run_insertion_merge_sorter_chk #(
    parameter int MAX_ITEMS  = 64,
    parameter int RUN_LENGTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending_count
);
    import rims_pkg::*;

    typedef struct packed {
        value_t value;
        logic   last;
        logic   ovf;
    } sorted_beat_t;

    value_t       set_values[$];
    logic         set_dropped;
    sorted_beat_t sorted_queue[$];

    // Stable sort: insertion over fixed runs, then bottom-up merges.
    function automatic void predict_sorted_set();
        value_t a[$];
        value_t tmp[$];
        value_t t;
        int     n, lo, hi, mid, w, i, j, p, q, k;
        a = set_values;
        n = a.size();
        for (lo = 0; lo < n; lo += RUN_LENGTH) begin
            hi = (lo + RUN_LENGTH > n) ? n : lo + RUN_LENGTH;
            for (i = lo + 1; i < hi; i++) begin
                t = a[i];
                j = i;
                while (j > lo && $signed(a[j-1]) > $signed(t)) begin
                    a[j] = a[j-1];
                    j--;
                end
                a[j] = t;
            end
        end
        for (w = RUN_LENGTH; w < n; w *= 2) begin
            for (lo = 0; lo < n; lo += 2 * w) begin
                mid = lo + w;
                if (mid >= n) continue;
                hi = (lo + 2 * w > n) ? n : lo + 2 * w;
                tmp = a;
                p = lo; q = mid; k = lo;
                while (p < mid && q < hi) begin
                    if (!($signed(tmp[p]) > $signed(tmp[q]))) a[k++] = tmp[p++];
                    else a[k++] = tmp[q++];
                end
                while (p < mid) a[k++] = tmp[p++];
                while (q < hi) a[k++] = tmp[q++];
            end
        end
        for (i = 0; i < n; i++)
            sorted_queue.push_back('{value: a[i], last: (i == n - 1), ovf: set_dropped});
    endfunction

    assign pending_count = sorted_queue.size();

    always @(posedge aclk) begin
        sorted_beat_t exp_beat;
        if (!aresetn) begin
            set_values.delete();
            set_dropped = 1'b0;
            sorted_queue.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (sorted_queue.size() == 0) begin
                    $display("%0t: unexpected beat value=%h last=%b ovf=%b",
                             $time, m_tdata, m_tlast, m_tuser);
                    fail_count++;
                end else begin
                    exp_beat = sorted_queue.pop_front();
                    if (exp_beat.value !== m_tdata || exp_beat.last !== m_tlast
                        || exp_beat.ovf !== m_tuser) begin
                        $display("%0t: mismatch expected value=%h last=%b ovf=%b, actual value=%h last=%b ovf=%b",
                                 $time, exp_beat.value, exp_beat.last, exp_beat.ovf,
                                 m_tdata, m_tlast, m_tuser);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (set_values.size() < MAX_ITEMS) set_values.push_back(s_tdata);
                else set_dropped = 1'b1;
                if (s_tlast) begin
                    predict_sorted_set();
                    set_values.delete();
                    set_dropped = 1'b0;
                end
            end
        end
    end
endmodule

@@ test/run_insertion_merge_sorter_tb.sv @@
// Testbench top for the run insertion / merge sorter: stimulus, idling phases and verdict.
module run_insertion_merge_sorter_tb;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          pending_count;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles = 0;
    int          sent_items = 0;

    localparam int WatchdogLimit = 200000;

    always #5 aclk = ~aclk;

    run_insertion_merge_sorter dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    run_insertion_merge_sorter_chk chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // Receiver stalls at random per phase.
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Drive one beat; idle first at random, then hold until accepted.
    task automatic send_beat(input logic [63:0] value, input logic last);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_items++;
    endtask

    function automatic logic [63:0] rand_value();
        case ($urandom_range(7))
            0: rand_value = 64'h8000_0000_0000_0000;
            1: rand_value = 64'h7fff_ffff_ffff_ffff;
            2: rand_value = 64'(int'($urandom_range(6)) - 3);
            3: rand_value = {60'h0, 4'($urandom_range(15))};
            default: rand_value = {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_set(input int n);
        int i;
        for (i = 0; i < n; i++) send_beat(rand_value(), i == n - 1);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    initial begin
        int phase, n;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: single element, extremes with ties, two runs, overflow.
        send_beat(64'h8000_0000_0000_0000, 1'b1);
        send_beat(64'h7fff_ffff_ffff_ffff, 1'b0);
        send_beat(64'h8000_0000_0000_0000, 1'b0);
        send_beat(64'hffff_ffff_ffff_ffff, 1'b0);
        send_beat(64'h0, 1'b0);
        send_beat(64'h7fff_ffff_ffff_ffff, 1'b0);
        send_beat(64'h5555_5555_5555_5555, 1'b0);
        send_beat(64'haaaa_aaaa_aaaa_aaaa, 1'b1);
        send_set(33);
        send_set(66);  // overflow, drop includes the last beat
        send_set(64);
        drain();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            repeat (2) begin
                case ($urandom_range(9))
                    0: n = 64;
                    1: n = 32 + $urandom_range(31);
                    2: n = 65 + $urandom_range(3);
                    default: n = 1 + $urandom_range(20);
                endcase
                send_set(n);
            end
            send_idle_pct = 0;
            recv_stall_pct = 0;
            repeat (2) send_set(1 + $urandom_range(8));
        end

        drain();
        repeat (100) @(posedge aclk);
        if (fail_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/core/rims_pkg.sv
rtl/core/rims_ram.sv
rtl/core/rims_front.sv
rtl/core/rims_back.sv
rtl/core/run_insertion_merge_sorter.sv
test/run_insertion_merge_sorter_chk.sv
test/run_insertion_merge_sorter_tb.sv
